// ===== hw/rtl/connection_timeout_queue_assert.svh =====
// assertion macros for the timeout queue
`ifndef CONNECTION_TIMEOUT_QUEUE_ASSERT_SVH
`define CONNECTION_TIMEOUT_QUEUE_ASSERT_SVH

// same-cycle implication
`define CTQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CTQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/ctq_pkg.sv =====
`default_nettype none
package ctq_pkg;

  localparam int DL_W   = 48;
  localparam int HD_W   = 6;
  localparam int TMO_W  = 32;
  localparam int WAIT_W = 31;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_DEL   = 2'd1;
  localparam logic [1:0] ACT_QUERY = 2'd2;
  localparam logic [1:0] ACT_EXP   = 2'd3;

  localparam logic [1:0] CELL_HOLD  = 2'd0;
  localparam logic [1:0] CELL_INS   = 2'd1;
  localparam logic [1:0] CELL_REM   = 2'd2;
  localparam logic [1:0] CELL_SHIFT = 2'd3;

  typedef struct packed {
    logic            vld;
    logic [DL_W-1:0] dl;
    logic [HD_W-1:0] hd;
  } ent_t;

  typedef struct packed {
    logic [1:0] op;
    ent_t       nkey;
    ent_t       tkey;
  } cell_ctl_t;

  // order by deadline, lower handle first on ties
  function automatic logic key_lt(input ent_t a, input ent_t b);
    return {a.dl, a.hd} < {b.dl, b.hd};
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/ctq_ram.sv =====
`default_nettype none
module ctq_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] wa,
  input  wire logic [WIDTH-1:0]         wd,
  input  wire logic [$clog2(DEPTH)-1:0] ra,
  output      logic [WIDTH-1:0]         rd
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[wa] <= wd;
    end
    rd <= mem_r[ra];
  end

endmodule
`default_nettype wire

// ===== hw/rtl/ctq_cell.sv =====
`default_nettype none
module ctq_cell (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire ctq_pkg::cell_ctl_t ctl_i,
  input  wire ctq_pkg::ent_t      left_i,
  input  wire logic               left_gt_i,
  input  wire ctq_pkg::ent_t      right_i,
  output      ctq_pkg::ent_t      ent_o,
  output      logic               gt_o
);
  import ctq_pkg::*;

  logic            vld_r;
  logic [DL_W-1:0] dl_r;
  logic [HD_W-1:0] hd_r;
  ent_t            cur;
  ent_t            ent_nxt;
  logic            ge;

  assign cur   = '{vld: vld_r, dl: dl_r, hd: hd_r};
  assign ent_o = cur;
  // new key goes before this entry
  assign gt_o  = !cur.vld || key_lt(ctl_i.nkey, cur);
  // this entry is at or past the removed one
  assign ge    = cur.vld && !key_lt(cur, ctl_i.tkey);

  always_comb begin
    ent_nxt = cur;
    case (ctl_i.op)
      CELL_INS: begin
        if (left_gt_i) begin
          ent_nxt = left_i;
        end else if (gt_o) begin
          ent_nxt = ctl_i.nkey;
        end
      end
      CELL_REM: begin
        if (ge) begin
          ent_nxt = right_i;
        end
      end
      CELL_SHIFT: begin
        ent_nxt = right_i;
      end
      default: begin
        ent_nxt = cur;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else begin
      vld_r <= ent_nxt.vld;
    end
  end

  always_ff @(posedge clk) begin
    dl_r <= ent_nxt.dl;
    hd_r <= ent_nxt.hd;
  end

endmodule
`default_nettype wire

// ===== hw/rtl/connection_timeout_queue.sv =====
// channel  direction  fields
// in_      input      action, handle, timeout_ms, now_ms
// out_     output     kind, status, expired_valid, expired_handle, no_timer,
//                     wait_ms, last
//
// add runs a deadline ram lookup, then a remove step and an insert step along the
// sorted cell chain, then the result; delete skips the insert step, query has only the result.
// an add for a handle not below SLOTS skips the insert step.
// expire gives one result per due timer, one chain shift per result, or a single result if none is due.
// reset clears the chain and the armed flags directly, no clearing pass.
// a stall on the result side holds the sequencer in its result step.
`default_nettype none
`include "connection_timeout_queue_assert.svh"
module connection_timeout_queue #(
  parameter int SLOTS = 64
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire logic [1:0]                  in_action,
  input  wire logic [ctq_pkg::HD_W-1:0]    in_handle,
  input  wire logic [ctq_pkg::TMO_W-1:0]   in_timeout_ms,
  input  wire logic [ctq_pkg::DL_W-1:0]    in_now_ms,
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      logic [1:0]                  out_kind,
  output      logic                        out_status,
  output      logic                        out_expired_valid,
  output      logic [ctq_pkg::HD_W-1:0]    out_expired_handle,
  output      logic                        out_no_timer,
  output      logic [ctq_pkg::WAIT_W-1:0]  out_wait_ms,
  output      logic                        out_last
);
  import ctq_pkg::*;

  localparam int IW = $clog2(SLOTS);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_INS  = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_EXP  = 3'd4;

  logic [2:0]        state_r, state_nxt;
  logic [1:0]        act_r;
  logic [HD_W-1:0]   hd_r;
  logic [DL_W-1:0]   now_r;
  logic [DL_W-1:0]   ndl_r;
  logic              inr_r;
  logic              st_r, st_nxt;
  logic [SLOTS-1:0]  armed_r, armed_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic [1:0]        kind_r, kind_nxt;
  logic              status_r, status_nxt;
  logic              xv_r, xv_nxt;
  logic [HD_W-1:0]   xh_r, xh_nxt;
  logic              nt_r, nt_nxt;
  logic [WAIT_W-1:0] wait_r, wait_nxt;
  logic              last_r, last_nxt;
  logic              out_load;

  logic              accept;
  logic              out_free;
  logic [DL_W:0]     sum;
  logic [DL_W-1:0]   ndl;
  logic              in_range;
  logic [DL_W-1:0]   rdata;
  logic              old_arm;
  logic [DL_W-1:0]   diff;
  logic [WAIT_W-1:0] wait_calc;
  logic              due0, due1;

  cell_ctl_t         ctl;
  ent_t              ents [SLOTS];
  logic [SLOTS-1:0]  gts;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  assign sum      = {1'b0, in_now_ms} + (DL_W+1)'(in_timeout_ms);
  assign ndl      = sum[DL_W] ? {DL_W{1'b1}} : sum[DL_W-1:0];
  assign in_range = ({1'b0, in_handle} < (HD_W+1)'(SLOTS));

  ctq_ram #(.WIDTH(DL_W), .DEPTH(SLOTS)) u_ram (
    .clk (clk),
    .we  ((state_r == S_INS) && inr_r),
    .wa  (hd_r[IW-1:0]),
    .wd  (ndl_r),
    .ra  (in_handle[IW-1:0]),
    .rd  (rdata)
  );

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    ent_t left_e;
    ent_t right_e;
    logic left_gt;
    if (i == 0) begin : g_first
      assign left_e  = '0;
      assign left_gt = 1'b0;
    end else begin : g_mid
      assign left_e  = ents[i-1];
      assign left_gt = gts[i-1];
    end
    if (i == SLOTS-1) begin : g_last
      assign right_e = '0;
    end else begin : g_body
      assign right_e = ents[i+1];
    end
    ctq_cell u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .ctl_i     (ctl),
      .left_i    (left_e),
      .left_gt_i (left_gt),
      .right_i   (right_e),
      .ent_o     (ents[i]),
      .gt_o      (gts[i])
    );
  end

  assign old_arm   = inr_r && armed_r[hd_r[IW-1:0]];
  assign diff      = ents[0].dl - now_r;
  assign wait_calc = (ents[0].dl <= now_r) ? '0 :
                     (|diff[DL_W-1:WAIT_W]) ? {WAIT_W{1'b1}} : diff[WAIT_W-1:0];
  assign due0      = ents[0].vld && (ents[0].dl <= now_r);
  assign due1      = ents[1].vld && (ents[1].dl <= now_r);

  always_comb begin
    state_nxt     = state_r;
    st_nxt        = st_r;
    armed_nxt     = armed_r;
    ctl.op        = CELL_HOLD;
    ctl.nkey      = '{vld: 1'b1, dl: ndl_r, hd: hd_r};
    ctl.tkey      = '{vld: 1'b1, dl: rdata, hd: hd_r};
    out_load      = 1'b0;
    kind_nxt      = act_r;
    status_nxt    = 1'b0;
    xv_nxt        = 1'b0;
    xh_nxt        = '0;
    nt_nxt        = 1'b0;
    wait_nxt      = '0;
    last_nxt      = 1'b1;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          st_nxt = 1'b0;
          case (in_action)
            ACT_ADD:   state_nxt = S_LOOK;
            ACT_DEL:   state_nxt = S_LOOK;
            ACT_QUERY: state_nxt = S_EMIT;
            default:   state_nxt = S_EXP;
          endcase
        end
      end
      S_LOOK: begin
        if (old_arm) begin
          ctl.op = CELL_REM;
          armed_nxt[hd_r[IW-1:0]] = 1'b0;
        end
        if (act_r == ACT_ADD) begin
          state_nxt = inr_r ? S_INS : S_EMIT;
        end else begin
          st_nxt    = !old_arm;
          state_nxt = S_EMIT;
        end
      end
      S_INS: begin
        ctl.op = CELL_INS;
        armed_nxt[hd_r[IW-1:0]] = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) begin
          out_load   = 1'b1;
          status_nxt = st_r;
          if (act_r == ACT_QUERY) begin
            nt_nxt   = !ents[0].vld;
            wait_nxt = ents[0].vld ? wait_calc : '0;
          end
          state_nxt = S_IDLE;
        end
      end
      S_EXP: begin
        if (out_free) begin
          out_load = 1'b1;
          if (due0) begin
            ctl.op   = CELL_SHIFT;
            armed_nxt[ents[0].hd[IW-1:0]] = 1'b0;
            xv_nxt   = 1'b1;
            xh_nxt   = ents[0].hd;
            last_nxt = !due1;
            if (!due1) begin
              state_nxt = S_IDLE;
            end
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      armed_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      armed_r     <= armed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    if (accept) begin
      act_r <= in_action;
      hd_r  <= in_handle;
      now_r <= in_now_ms;
      ndl_r <= ndl;
      inr_r <= in_range;
    end
    if (out_load) begin
      kind_r   <= kind_nxt;
      status_r <= status_nxt;
      xv_r     <= xv_nxt;
      xh_r     <= xh_nxt;
      nt_r     <= nt_nxt;
      wait_r   <= wait_nxt;
      last_r   <= last_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_kind           = kind_r;
  assign out_status         = status_r;
  assign out_expired_valid  = xv_r;
  assign out_expired_handle = xh_r;
  assign out_no_timer       = nt_r;
  assign out_wait_ms        = wait_r;
  assign out_last           = last_r;

  `CTQ_ASSERT_NOW(a_head_armed, ents[0].vld, armed_r[ents[0].hd[IW-1:0]], "chain head not armed")
  `CTQ_ASSERT_NOW(a_head_sorted, ents[1].vld, ents[0].vld && key_lt(ents[0], ents[1]), "chain out of order")
  `CTQ_ASSERT_NEXT(a_exp_end, (state_r == S_EXP) && out_free && !due1, state_r == S_IDLE && out_last, "expire did not end")

endmodule
`default_nettype wire
